/* src/f8cv_pkg.sv */
// Package: mode codes and fp8 constants for the fp8 format converter.
package f8cv_pkg;

    typedef enum logic [1:0] {
        MODE_INT_TO_FP8   = 2'd0,
        MODE_FP8_TO_INT   = 2'd1,
        MODE_FLT_TO_FP8   = 2'd2,
        MODE_FP8_TO_FLT   = 2'd3
    } t_mode;

    localparam logic [7:0]  FP8_POS_INF  = 8'h78;
    localparam logic [7:0]  FP8_NEG_INF  = 8'hF8;
    localparam logic [7:0]  FP8_POS_NAN  = 8'h7C;
    localparam logic [7:0]  FP8_NEG_NAN  = 8'hFC;
    localparam logic [31:0] INT_INF_CODE = 32'h8000_0000;
    localparam logic [31:0] MAX_MAG      = 32'd240;
    localparam logic [31:0] FLT_MAX_MAG  = 32'h4370_0000;
    localparam logic [7:0]  EXP_REBIAS   = 8'd120;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] int_value;
        logic [31:0] float_bits;
        logic [7:0]  tiny_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  tiny_result;
        logic [31:0] int_result;
        logic [31:0] float_result;
    } t_out_item;

endpackage

/* src/f8cv_if.sv */
// Interfaces: valid/ready channels for input and result items.
interface f8cv_in_if import f8cv_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface f8cv_out_if import f8cv_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/f8cv_core.sv */
// Core: three-stage conversion datapath with per-stage valid bits and stall.
module f8cv_core import f8cv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_item
);

    // stage 1: decode, magnitude, special-case classification
    logic        r_v1;
    logic [1:0]  r_mode1;
    logic        r_sign1;
    logic [31:0] r_mag1;
    logic [7:0]  r_special1;
    logic        r_is_spec1;
    logic [7:0]  r_tv1;
    logic [31:0] r_fb1;

    // stage 2: leading one / shift amounts
    logic        r_v2;
    logic [1:0]  r_mode2;
    logic        r_sign2;
    logic [31:0] r_mag2;
    logic [7:0]  r_special2;
    logic        r_is_spec2;
    logic [7:0]  r_tv2;
    logic [31:0] r_fb2;
    logic [4:0]  r_lpos2;

    logic        r_v3;
    t_out_item   r_out3;

    logic        n_sign1;
    logic [31:0] n_mag1;
    logic [7:0]  n_special1;
    logic        n_is_spec1;
    logic [4:0]  n_lpos2;
    t_out_item   n_out3;

    logic [7:0]  fe1;
    logic [22:0] fm1;
    logic [7:0]  fe;
    logic [22:0] fm;
    logic [3:0]  te;
    logic [2:0]  tf;
    logic [7:0]  sh;
    logic [23:0] sm;
    logic [4:0]  fp;
    logic [3:0]  fv;
    logic [4:0]  tp;
    logic [31:0] tmag;
    logic [31:0] ssm;

    always_comb begin
        n_sign1    = 1'b0;
        n_mag1     = '0;
        n_special1 = '0;
        n_is_spec1 = 1'b0;
        fe1 = i_item.float_bits[30:23];
        fm1 = i_item.float_bits[22:0];
        unique case (t_mode'(i_item.mode))
            MODE_INT_TO_FP8: begin
                n_sign1 = i_item.int_value[31];
                n_mag1  = n_sign1 ? (32'd0 - i_item.int_value) : i_item.int_value;
                if (i_item.int_value == '0) begin
                    n_is_spec1 = 1'b1;
                    n_special1 = '0;
                end else if (n_sign1 && (i_item.int_value == INT_INF_CODE
                                         || n_mag1 > MAX_MAG)) begin
                    n_is_spec1 = 1'b1;
                    n_special1 = FP8_NEG_INF;
                end else if (!n_sign1 && n_mag1 > MAX_MAG) begin
                    n_is_spec1 = 1'b1;
                    n_special1 = FP8_POS_INF;
                end
            end
            MODE_FLT_TO_FP8: begin
                n_sign1 = i_item.float_bits[31];
                n_mag1  = {1'b0, i_item.float_bits[30:0]};
                if (fe1 == 8'hFF && fm1 != '0) begin
                    n_is_spec1 = 1'b1;
                    n_special1 = n_sign1 ? FP8_NEG_NAN : FP8_POS_NAN;
                end else if (n_mag1 > FLT_MAX_MAG) begin
                    n_is_spec1 = 1'b1;
                    n_special1 = n_sign1 ? FP8_NEG_INF : FP8_POS_INF;
                end
            end
            MODE_FP8_TO_INT, MODE_FP8_TO_FLT: begin
                n_sign1 = i_item.tiny_value[7];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mode1    <= i_item.mode;
            r_sign1    <= n_sign1;
            r_mag1     <= n_mag1;
            r_special1 <= n_special1;
            r_is_spec1 <= n_is_spec1;
            r_tv1      <= i_item.tiny_value;
            r_fb1      <= i_item.float_bits;
            r_mode2    <= r_mode1;
            r_sign2    <= r_sign1;
            r_mag2     <= r_mag1;
            r_special2 <= r_special1;
            r_is_spec2 <= r_is_spec1;
            r_tv2      <= r_tv1;
            r_fb2      <= r_fb1;
            r_lpos2    <= n_lpos2;
            r_out3     <= n_out3;
        end
    end

    // leading one of an int magnitude (at most 240, so 8 bits)
    always_comb begin
        n_lpos2 = '0;
        for (int k = 1; k < 8; k++) begin
            if (r_mag1[k]) n_lpos2 = 5'(k);
        end
    end

    always_comb begin
        n_out3 = '0;
        te   = r_tv2[6:3];
        tf   = r_tv2[2:0];
        fe   = r_fb2[30:23];
        fm   = r_fb2[22:0];
        sh   = 8'd141 - fe;
        sm   = {1'b1, fm};
        fp   = '0;
        fv   = '0;
        tp   = '0;
        tmag = '0;
        ssm  = '0;
        unique case (t_mode'(r_mode2))
            MODE_INT_TO_FP8: begin
                if (r_is_spec2) begin
                    n_out3.tiny_result = r_special2;
                end else begin
                    if (r_lpos2 < 5'd3)
                        ssm = r_mag2 << (5'd3 - r_lpos2);
                    else
                        ssm = r_mag2 >> (r_lpos2 - 5'd3);
                    n_out3.tiny_result = {r_sign2, 4'(r_lpos2 + 5'd7), ssm[2:0]};
                end
            end
            MODE_FLT_TO_FP8: begin
                if (r_is_spec2) begin
                    n_out3.tiny_result = r_special2;
                end else if (fe < 8'd121) begin
                    if (sh >= 8'd24)
                        n_out3.tiny_result = {r_sign2, 7'd0};
                    else begin
                        sm = sm >> sh[4:0];
                        n_out3.tiny_result = {r_sign2, 4'd0, sm[2:0]};
                    end
                end else begin
                    n_out3.tiny_result = {r_sign2, 4'(fe - EXP_REBIAS), fm[22:20]};
                end
            end
            MODE_FP8_TO_INT: begin
                if (te == 4'd15) begin
                    n_out3.int_result = INT_INF_CODE;
                end else begin
                    if (te >= 4'd10)
                        tmag = {28'd0, 1'b1, tf} << (te - 4'd10);
                    else
                        tmag = {28'd0, 1'b1, tf} >> (4'd10 - te);
                    n_out3.int_result = r_sign2 ? (32'd0 - tmag) : tmag;
                end
            end
            MODE_FP8_TO_FLT: begin
                if (te == 4'd15) begin
                    n_out3.float_result = {r_sign2,
                        (tf == '0) ? 31'h7F80_0000 : 31'h7FC0_0000};
                end else if (te != '0) begin
                    n_out3.float_result = {r_sign2, 8'(te) + EXP_REBIAS, tf, 20'd0};
                end else if (tf != '0) begin
                    tp = tf[2] ? 5'd2 : (tf[1] ? 5'd1 : 5'd0);
                    fv = {1'b0, tf} - (4'd1 << tp);
                    fp = 5'd23 - tp;
                    n_out3.float_result = {r_sign2, 8'(tp) + 8'd118,
                        23'({19'd0, fv} << fp)};
                end else begin
                    n_out3.float_result = {r_sign2, 31'd0};
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_v3;
    assign o_item  = r_out3;

endmodule

/* src/fp8_e4m3_format_converter.sv */
// Top level: fp8 <-> int32 / binary32 converter with valid/ready channels.
//  channel   dir  payload
//  in_ch     in   mode, int_value, float_bits, tiny_value
//  out_ch    out  tiny_result, int_result, float_result
// One item per cycle while the output is not stalled; each item passes through the three register stages.
// Reset clears the stage valid bits only.
// A stall on the output holds every stage; a stage moves when the last is empty or taken.
module fp8_e4m3_format_converter import f8cv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    f8cv_in_if.sink    in_ch,
    f8cv_out_if.source out_ch
);

    logic adv;
    logic out_valid;

    assign adv         = !out_valid || out_ch.ready;
    assign in_ch.ready = adv && i_rst_n;
    assign out_ch.valid = out_valid;

    f8cv_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (in_ch.valid),
        .i_item  (in_ch.data),
        .o_valid (out_valid),
        .o_item  (out_ch.data)
    );

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed during stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_one_hot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> $countones({out_ch.data.tiny_result != '0,
            out_ch.data.int_result != '0, out_ch.data.float_result != '0}) <= 1)
        else $error("more than one result field set");
`endif

endmodule
